### hdl/nmi_pkg.sv
// nmi_pkg: shared types, constants and the step program of the modal integrator
// no dependencies; used by the interfaces, the arithmetic unit and the top level
package nmi_pkg;

  typedef logic signed [47:0] q_t;

  localparam q_t QMAX   = 48'sh7FFF_FFFF_FFFF;
  localparam q_t QMIN   = 48'sh8000_0000_0000;
  localparam q_t HALF   = 48'sd8388608;
  localparam q_t BETA   = 48'sd1398101;
  localparam q_t FIVE12 = 48'sd6990507;

  localparam int NUM_CFG = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    CFG_MASS_PLUNGE    = 3'd0,
    CFG_MASS_PITCH     = 3'd1,
    CFG_DAMPING_PLUNGE = 3'd2,
    CFG_DAMPING_PITCH  = 3'd3,
    CFG_OMEGA_PLUNGE   = 3'd4,
    CFG_OMEGA_PITCH    = 3'd5,
    CFG_SHAPE_PLUNGE   = 3'd6,
    CFG_SHAPE_PITCH    = 3'd7
  } cfg_idx_t;

  localparam q_t RST_MASS_PLUNGE    = 48'sd16777216;
  localparam q_t RST_MASS_PITCH     = 48'sd16777216;
  localparam q_t RST_DAMPING_PLUNGE = 48'sd0;
  localparam q_t RST_DAMPING_PITCH  = 48'sd0;
  localparam q_t RST_OMEGA_PLUNGE   = 48'sd351021637;
  localparam q_t RST_OMEGA_PITCH    = 48'sd548113325;
  localparam q_t RST_SHAPE_PLUNGE   = 48'sd1613183;
  localparam q_t RST_SHAPE_PITCH    = -48'sd446629623;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic done;
    q_t   y;
  } alu_res_t;

  // operand and destination codes; mode dependent ones follow the current mode
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_HALF, SRC_BETA, SRC_FIVE12, SRC_DT, SRC_DT2,
    SRC_F, SRC_M, SRC_D, SRC_W, SRC_S,
    SRC_DISP, SRC_VEL, SRC_ACC,
    SRC_T0, SRC_T1, SRC_T2, SRC_CW, SRC_KK, SRC_A0, SRC_B1, SRC_B3,
    SRC_AN, SRC_VN, SRC_DN, SRC_RES
  } src_t;

  typedef struct packed {
    alu_op_t op;
    logic    first_only;
    src_t    dst;
    src_t    a;
    src_t    b;
  } instr_t;

  localparam int PROG_LEN = 36;
  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

  function automatic instr_t ins(alu_op_t op, logic fo, src_t dst, src_t a, src_t b);
    instr_t i;
    i.op = op;
    i.first_only = fo;
    i.dst = dst;
    i.a = a;
    i.b = b;
    return i;
  endfunction

  // one newmark step of one mode
  function automatic instr_t prog_at(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = ins(OP_MUL, 1'b0, SRC_DT2, SRC_DT,  SRC_DT);
      6'd1:  i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_D,   SRC_W);
      6'd2:  i = ins(OP_ADD, 1'b0, SRC_CW,  SRC_T0,  SRC_T0);
      6'd3:  i = ins(OP_MUL, 1'b0, SRC_KK,  SRC_W,   SRC_W);
      6'd4:  i = ins(OP_ADD, 1'b0, SRC_A0,  SRC_ACC, SRC_ZERO);
      6'd5:  i = ins(OP_MUL, 1'b1, SRC_T0,  SRC_CW,  SRC_VEL);
      6'd6:  i = ins(OP_SUB, 1'b1, SRC_T0,  SRC_F,   SRC_T0);
      6'd7:  i = ins(OP_MUL, 1'b1, SRC_T1,  SRC_KK,  SRC_DISP);
      6'd8:  i = ins(OP_SUB, 1'b1, SRC_T0,  SRC_T0,  SRC_T1);
      6'd9:  i = ins(OP_DIV, 1'b1, SRC_A0,  SRC_T0,  SRC_M);
      6'd10: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_DT,  SRC_A0);
      6'd11: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_HALF, SRC_T0);
      6'd12: i = ins(OP_ADD, 1'b0, SRC_B1,  SRC_VEL, SRC_T0);
      6'd13: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_DT,  SRC_VEL);
      6'd14: i = ins(OP_ADD, 1'b0, SRC_T0,  SRC_DISP, SRC_T0);
      6'd15: i = ins(OP_MUL, 1'b0, SRC_T1,  SRC_DT2, SRC_A0);
      6'd16: i = ins(OP_MUL, 1'b0, SRC_T1,  SRC_FIVE12, SRC_T1);
      6'd17: i = ins(OP_ADD, 1'b0, SRC_B3,  SRC_T0,  SRC_T1);
      6'd18: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_DT,  SRC_CW);
      6'd19: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_HALF, SRC_T0);
      6'd20: i = ins(OP_ADD, 1'b0, SRC_T0,  SRC_M,   SRC_T0);
      6'd21: i = ins(OP_MUL, 1'b0, SRC_T1,  SRC_DT2, SRC_KK);
      6'd22: i = ins(OP_MUL, 1'b0, SRC_T1,  SRC_BETA, SRC_T1);
      6'd23: i = ins(OP_ADD, 1'b0, SRC_T2,  SRC_T0,  SRC_T1);
      6'd24: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_CW,  SRC_B1);
      6'd25: i = ins(OP_SUB, 1'b0, SRC_T0,  SRC_F,   SRC_T0);
      6'd26: i = ins(OP_MUL, 1'b0, SRC_T1,  SRC_KK,  SRC_B3);
      6'd27: i = ins(OP_SUB, 1'b0, SRC_T0,  SRC_T0,  SRC_T1);
      6'd28: i = ins(OP_DIV, 1'b0, SRC_AN,  SRC_T0,  SRC_T2);
      6'd29: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_DT,  SRC_AN);
      6'd30: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_HALF, SRC_T0);
      6'd31: i = ins(OP_ADD, 1'b0, SRC_VN,  SRC_B1,  SRC_T0);
      6'd32: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_DT2, SRC_AN);
      6'd33: i = ins(OP_MUL, 1'b0, SRC_T0,  SRC_BETA, SRC_T0);
      6'd34: i = ins(OP_ADD, 1'b0, SRC_DN,  SRC_B3,  SRC_T0);
      6'd35: i = ins(OP_MUL, 1'b0, SRC_RES, SRC_DN,  SRC_S);
      default: i = ins(OP_ADD, 1'b0, SRC_T0, SRC_ZERO, SRC_ZERO);
    endcase
    return i;
  endfunction

endpackage

### hdl/nmi_in_if.sv
// nmi_in_if: request channel carrying modal forces, step and commit flag
// depends on nmi_pkg
interface nmi_in_if import nmi_pkg::*;;
  logic        valid;
  logic        ready;
  q_t          force_plunge;
  q_t          force_pitch;
  logic [31:0] base_step;
  logic [9:0]  step_multiplier;
  logic        commit;

  modport source (output valid, force_plunge, force_pitch, base_step, step_multiplier,
                  commit, input ready);
  modport sink (input valid, force_plunge, force_pitch, base_step, step_multiplier,
                commit, output ready);
endinterface

### hdl/nmi_out_if.sv
// nmi_out_if: result channel carrying pitch angle and plunge offset
// depends on nmi_pkg
interface nmi_out_if import nmi_pkg::*;;
  logic valid;
  logic ready;
  q_t   pitch_angle;
  q_t   plunge_offset;

  modport source (output valid, pitch_angle, plunge_offset, input ready);
  modport sink (input valid, pitch_angle, plunge_offset, output ready);
endinterface

### hdl/nmi_alu.sv
// nmi_alu: shared saturating q24.24 unit; add/sub, multiply from
// four 24x24 partial products, divide by restoring long division; uses nmi_pkg
module nmi_alu import nmi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  alu_op_t  op,
  input  q_t       a,
  input  q_t       b,
  output alu_res_t res
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} ast_t;

  localparam int DVD_W = 73;

  ast_t              st_r;
  logic [6:0]        cnt_r;
  logic [47:0]       ma_r, mb_r;
  logic              neg_r, ovf_r, done_r;
  logic [50:0]       acc_r;
  logic [47:0]       rem_r;
  logic [DVD_W-1:0]  dvd_r, quo_r;
  q_t                y_r;

  function automatic q_t from_mag(logic [50:0] m, logic neg);
    if (neg) begin
      if (m > 51'h8000_0000_0000) return QMIN;
      return q_t'(-$signed({3'b0, m[47:0]}));
    end
    if (m > 51'h7FFF_FFFF_FFFF) return QMAX;
    return q_t'(m[47:0]);
  endfunction

  function automatic q_t sat_sum(logic signed [48:0] s);
    if (s[48] != s[47]) return s[48] ? QMIN : QMAX;
    return s[47:0];
  endfunction

  logic [47:0] ma, mb;
  logic [23:0] mx, my;
  logic [47:0] prod;
  logic [48:0] rem_sh;
  logic        qbit;
  logic [DVD_W-1:0] quo_nxt;
  logic [50:0] mul_m;
  logic [49:0] div_m;

  always_comb begin
    ma = a[47] ? 48'(-a) : 48'(a);
    mb = b[47] ? 48'(-b) : 48'(b);
    case (cnt_r[1:0])
      2'd0: begin mx = ma_r[47:24]; my = mb_r[47:24]; end
      2'd1: begin mx = ma_r[47:24]; my = mb_r[23:0]; end
      2'd2: begin mx = ma_r[23:0]; my = mb_r[47:24]; end
      default: begin mx = ma_r[23:0]; my = mb_r[23:0]; end
    endcase
    prod = 48'(mx) * 48'(my);
    mul_m = acc_r + 51'((49'(prod) + 49'h80_0000) >> 24);
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    qbit = rem_sh >= {1'b0, mb_r};
    quo_nxt = {quo_r[DVD_W-2:0], qbit};
    div_m = (50'(quo_nxt[48:0]) + 50'd1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        A_IDLE: begin
          if (start) begin
            ma_r <= ma;
            mb_r <= mb;
            neg_r <= a[47] ^ b[47];
            cnt_r <= '0;
            case (op)
              OP_ADD: begin
                y_r <= sat_sum(49'(a) + 49'(b));
                done_r <= 1'b1;
              end
              OP_SUB: begin
                y_r <= sat_sum(49'(a) - 49'(b));
                done_r <= 1'b1;
              end
              OP_MUL: st_r <= A_MUL;
              default: begin
                if (b == '0) begin
                  // zero divisor: extreme of the dividend sign, or zero
                  y_r <= (a == '0) ? '0 : (a[47] ? QMIN : QMAX);
                  done_r <= 1'b1;
                end else begin
                  dvd_r <= {ma, 25'b0};
                  rem_r <= '0;
                  quo_r <= '0;
                  st_r <= A_DIV;
                end
              end
            endcase
          end
        end
        A_MUL: begin
          cnt_r <= cnt_r + 7'd1;
          case (cnt_r[1:0])
            2'd0: begin
              acc_r <= {3'b0, prod[23:0], 24'b0};
              ovf_r <= prod[47:24] != '0;
            end
            2'd1, 2'd2: acc_r <= acc_r + 51'(prod);
            default: begin
              y_r <= from_mag(ovf_r ? 51'h8000_0000_0001 : mul_m, neg_r);
              done_r <= 1'b1;
              st_r <= A_IDLE;
            end
          endcase
        end
        A_DIV: begin
          cnt_r <= cnt_r + 7'd1;
          dvd_r <= dvd_r << 1;
          // remainder stays below the divisor, so 48 bits hold it
          rem_r <= qbit ? 48'(rem_sh - {1'b0, mb_r}) : 48'(rem_sh);
          quo_r <= quo_nxt;
          if (cnt_r == 7'(DVD_W - 1)) begin
            if (quo_nxt[DVD_W-1:49] != '0) y_r <= neg_r ? QMIN : QMAX;
            else y_r <= from_mag(51'(div_m), neg_r);
            done_r <= 1'b1;
            st_r <= A_IDLE;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.y = y_r;

endmodule

### hdl/two_mode_newmark_integrator.sv
// two_mode_newmark_integrator: top level, sequencer, operand registers and state
// depends on nmi_pkg, nmi_in_if, nmi_out_if and nmi_alu
//
//  channel  dir  handshake        payload
//  in_if    in   valid/ready      force_plunge, force_pitch, base_step,
//                                 step_multiplier, commit
//  out_if   out  valid/ready      pitch_angle, plunge_offset
//  cfg      in   cfg_we           cfg_index, cfg_data (48 bit)
//
// one request runs the 36-step program once per mode on the shared unit, one
// operation at a time: add/sub, product or quotient; a zero divisor skips the long
// division, and the start-up steps run only before the first commit
// in_if.ready is high only while idle; one result waits in the output register,
// a finished request holds until that register is free
// synchronous active-low reset restores register defaults and zero state
module two_mode_newmark_integrator import nmi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nmi_in_if.sink               in_if,
  nmi_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} st_t;

  st_t             st_r;
  logic [PC_W-1:0] pc_r;
  logic            mode_r;      // 0 plunge, 1 pitch
  logic            first_r;     // no step committed yet
  logic            commit_r;
  logic            out_valid_r;
  q_t              out_pitch_r, out_plunge_r;

  // configuration
  q_t mass_pl_r, mass_pi_r, damp_pl_r, damp_pi_r, omega_pl_r, omega_pi_r;
  q_t shape_pl_r, shape_pi_r;

  // request payload
  q_t fpl_r, fpi_r, dt_r, dt2_r;

  // committed state and next state per mode
  q_t disp_pl_r, vel_pl_r, acc_pl_r, disp_pi_r, vel_pi_r, acc_pi_r;
  q_t ndisp_pl_r, nvel_pl_r, nacc_pl_r, ndisp_pi_r, nvel_pi_r, nacc_pi_r;
  q_t res_pl_r, res_pi_r;

  // scratch shared by both modes
  q_t t0_r, t1_r, t2_r, cw_r, kk_r, a0_r, b1_r, b3_r;

  instr_t   ins_c;
  alu_res_t alu_res;
  q_t       opa, opb;
  logic     alu_start;
  logic [10:0] k_c;
  logic [41:0] step_prod;

  function automatic q_t pick(src_t s, logic m);
    case (s)
      SRC_ZERO:   return '0;
      SRC_HALF:   return HALF;
      SRC_BETA:   return BETA;
      SRC_FIVE12: return FIVE12;
      SRC_DT:     return dt_r;
      SRC_DT2:    return dt2_r;
      SRC_F:      return m ? fpi_r : fpl_r;
      SRC_M:      return m ? mass_pi_r : mass_pl_r;
      SRC_D:      return m ? damp_pi_r : damp_pl_r;
      SRC_W:      return m ? omega_pi_r : omega_pl_r;
      SRC_S:      return m ? shape_pi_r : shape_pl_r;
      SRC_DISP:   return m ? disp_pi_r : disp_pl_r;
      SRC_VEL:    return m ? vel_pi_r : vel_pl_r;
      SRC_ACC:    return m ? acc_pi_r : acc_pl_r;
      SRC_T0:     return t0_r;
      SRC_T1:     return t1_r;
      SRC_T2:     return t2_r;
      SRC_CW:     return cw_r;
      SRC_KK:     return kk_r;
      SRC_A0:     return a0_r;
      SRC_B1:     return b1_r;
      SRC_B3:     return b3_r;
      SRC_AN:     return m ? nacc_pi_r : nacc_pl_r;
      SRC_VN:     return m ? nvel_pi_r : nvel_pl_r;
      SRC_DN:     return m ? ndisp_pi_r : ndisp_pl_r;
      SRC_RES:    return m ? res_pi_r : res_pl_r;
      default:    return '0;
    endcase
  endfunction

  always_comb begin
    ins_c = prog_at(pc_r);
    opa = pick(ins_c.a, mode_r);
    opb = pick(ins_c.b, mode_r);
    // start-up steps are skipped once a step has been committed
    alu_start = (st_r == S_ISSUE) && !(ins_c.first_only && !first_r);
    // step in q24.24: base q0.32 times multiplier, shifted down by 8 bits with rounding
    k_c = (in_if.step_multiplier == '0) ? 11'd1 : {1'b0, in_if.step_multiplier};
    step_prod = 42'(in_if.base_step) * 42'(k_c);
  end

  nmi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .op    (ins_c.op),
    .a     (opa),
    .b     (opb),
    .res   (alu_res)
  );

  assign in_if.ready = (st_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.pitch_angle = out_pitch_r;
  assign out_if.plunge_offset = out_plunge_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_pl_r <= RST_MASS_PLUNGE;
      mass_pi_r <= RST_MASS_PITCH;
      damp_pl_r <= RST_DAMPING_PLUNGE;
      damp_pi_r <= RST_DAMPING_PITCH;
      omega_pl_r <= RST_OMEGA_PLUNGE;
      omega_pi_r <= RST_OMEGA_PITCH;
      shape_pl_r <= RST_SHAPE_PLUNGE;
      shape_pi_r <= RST_SHAPE_PITCH;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASS_PLUNGE:    mass_pl_r <= cfg_data;
        CFG_MASS_PITCH:     mass_pi_r <= cfg_data;
        CFG_DAMPING_PLUNGE: damp_pl_r <= cfg_data;
        CFG_DAMPING_PITCH:  damp_pi_r <= cfg_data;
        CFG_OMEGA_PLUNGE:   omega_pl_r <= cfg_data;
        CFG_OMEGA_PITCH:    omega_pi_r <= cfg_data;
        CFG_SHAPE_PLUNGE:   shape_pl_r <= cfg_data;
        CFG_SHAPE_PITCH:    shape_pi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, write-back and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      mode_r <= 1'b0;
      first_r <= 1'b1;
      commit_r <= 1'b0;
      out_valid_r <= 1'b0;
      disp_pl_r <= '0;
      vel_pl_r <= '0;
      acc_pl_r <= '0;
      disp_pi_r <= '0;
      vel_pi_r <= '0;
      acc_pi_r <= '0;
    end else begin
      // in S_FIN the hand-over below sets the output register instead
      if (out_valid_r && out_if.ready && (st_r != S_FIN)) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_if.valid) begin
            fpl_r <= in_if.force_plunge;
            fpi_r <= in_if.force_pitch;
            commit_r <= in_if.commit;
            dt_r <= q_t'((48'(step_prod) + 48'd128) >> 8);
            pc_r <= '0;
            mode_r <= 1'b0;
            st_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (alu_start) begin
            st_r <= S_WAIT;
          end else if (pc_r == PC_LAST) begin
            // never reached: the last step is never start-up only
            st_r <= S_FIN;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        S_WAIT: begin
          if (alu_res.done) begin
            case (ins_c.dst)
              SRC_DT2: dt2_r <= alu_res.y;
              SRC_T0:  t0_r <= alu_res.y;
              SRC_T1:  t1_r <= alu_res.y;
              SRC_T2:  t2_r <= alu_res.y;
              SRC_CW:  cw_r <= alu_res.y;
              SRC_KK:  kk_r <= alu_res.y;
              SRC_A0:  a0_r <= alu_res.y;
              SRC_B1:  b1_r <= alu_res.y;
              SRC_B3:  b3_r <= alu_res.y;
              SRC_AN:  if (mode_r) nacc_pi_r <= alu_res.y; else nacc_pl_r <= alu_res.y;
              SRC_VN:  if (mode_r) nvel_pi_r <= alu_res.y; else nvel_pl_r <= alu_res.y;
              SRC_DN:  if (mode_r) ndisp_pi_r <= alu_res.y; else ndisp_pl_r <= alu_res.y;
              SRC_RES: if (mode_r) res_pi_r <= alu_res.y; else res_pl_r <= alu_res.y;
              default: ;
            endcase
            if (pc_r == PC_LAST) begin
              pc_r <= '0;
              if (mode_r) begin
                st_r <= S_FIN;
              end else begin
                mode_r <= 1'b1;
                st_r <= S_ISSUE;
              end
            end else begin
              pc_r <= pc_r + 1'b1;
              st_r <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          // hand over once the output register is free
          if (!out_valid_r || out_if.ready) begin
            out_pitch_r <= res_pi_r;
            out_plunge_r <= res_pl_r;
            out_valid_r <= 1'b1;
            if (commit_r) begin
              disp_pl_r <= ndisp_pl_r;
              vel_pl_r <= nvel_pl_r;
              acc_pl_r <= nacc_pl_r;
              disp_pi_r <= ndisp_pi_r;
              vel_pi_r <= nvel_pi_r;
              acc_pi_r <= nacc_pi_r;
              first_r <= 1'b0;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_two_mode_newmark_integrator.sv
// tb_two_mode_newmark_integrator: self-checking bench for the two-mode newmark integrator
// depends on nmi_pkg, nmi_in_if, nmi_out_if and the two_mode_newmark_integrator rtl
module tb_two_mode_newmark_integrator import nmi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no accepted request or result before the run is declared hung
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    q_t disp;
    q_t vel;
    q_t acc;
  } mode_t;

  typedef struct {
    q_t pitch_angle;
    q_t plunge_offset;
  } angles_t;

  typedef struct {
    q_t          f_plunge;
    q_t          f_pitch;
    logic [31:0] base_step;
    logic [9:0]  mult;
    logic        commit;
  } req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [47:0] cfg_data;

  nmi_in_if  in_if ();
  nmi_out_if out_if ();

  two_mode_newmark_integrator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the modal state
  q_t      regs [NUM_CFG];
  mode_t   plunge_st;
  mode_t   pitch_st;
  bit      startup;
  angles_t angles_q[$];

  int  errors;
  int  idle_cycles;
  bit  calm;       // no idling on either side
  bit  hold_req;   // ask the receiver for one long hold-off

  // ---------------------------------------------------------------
  // fixed point helpers, Q24.24 saturating
  // ---------------------------------------------------------------
  function automatic q_t clamp_q(longint x);
    if (x > longint'(QMAX)) return QMAX;
    if (x < longint'(QMIN)) return QMIN;
    return q_t'(x);
  endfunction

  function automatic q_t from_mag(longint unsigned m, bit neg);
    if (neg) begin
      if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
      return q_t'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
    return q_t'(m);
  endfunction

  function automatic longint unsigned abs_q(q_t a);
    longint x;
    x = a;
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic q_t add_q(q_t a, q_t b);
    return clamp_q(longint'(a) + longint'(b));
  endfunction

  function automatic q_t sub_q(q_t a, q_t b);
    return clamp_q(longint'(a) - longint'(b));
  endfunction

  // exact product, rounded to nearest with ties away from zero
  function automatic q_t mul_q(q_t a, q_t b);
    longint unsigned ma, mb, a1, a0, b1, b0, m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = abs_q(a);
    mb = abs_q(b);
    a1 = ma >> 24;
    a0 = ma & 64'hFF_FFFF;
    b1 = mb >> 24;
    b0 = mb & 64'hFF_FFFF;
    if (a1 * b1 >= 64'h100_0000) m = 64'h8000_0000_0001;
    else m = ((a1 * b1) << 24) + a1 * b0 + a0 * b1 + ((a0 * b0 + 64'h80_0000) >> 24);
    return from_mag(m, neg);
  endfunction

  // restoring division with one guard bit for rounding
  function automatic q_t div_q(q_t n, q_t d);
    longint unsigned mn, md, q0, r, frac, m;
    bit neg;
    if (d == 0) begin
      if (n == 0) return '0;
      return (n > 0) ? QMAX : QMIN;
    end
    neg = (n < 0) != (d < 0);
    mn = abs_q(n);
    md = abs_q(d);
    q0 = mn / md;
    r = mn % md;
    frac = 0;
    if (q0 >= 64'h100_0000) begin
      m = 64'h8000_0000_0001;
    end else begin
      for (int i = 0; i < 25; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= md) begin
          r = r - md;
          frac = frac | 1;
        end
      end
      m = (q0 << 24) + ((frac + 1) >> 1);
    end
    return from_mag(m, neg);
  endfunction

  // one newmark step (gamma 1/2, beta 1/12) of one decoupled mode
  function automatic mode_t newmark_mode(mode_t s, q_t f, q_t m, q_t d, q_t w,
                                         q_t dt, q_t dt2, bit first);
    q_t cw, kk, acc, b1, b3, a_eff;
    mode_t nx;
    cw = add_q(mul_q(d, w), mul_q(d, w));
    kk = mul_q(w, w);
    acc = s.acc;
    // start-up: old acceleration from the equation of motion
    if (first) acc = div_q(sub_q(sub_q(f, mul_q(cw, s.vel)), mul_q(kk, s.disp)), m);
    b1 = add_q(s.vel, mul_q(HALF, mul_q(dt, acc)));
    b3 = add_q(add_q(s.disp, mul_q(dt, s.vel)), mul_q(FIVE12, mul_q(dt2, acc)));
    a_eff = add_q(add_q(m, mul_q(HALF, mul_q(dt, cw))), mul_q(BETA, mul_q(dt2, kk)));
    nx.acc = div_q(sub_q(sub_q(f, mul_q(cw, b1)), mul_q(kk, b3)), a_eff);
    nx.vel = add_q(b1, mul_q(HALF, mul_q(dt, nx.acc)));
    nx.disp = add_q(b3, mul_q(BETA, mul_q(dt2, nx.acc)));
    return nx;
  endfunction

  // expected angles for one accepted request, state kept only on commit
  task automatic predict_angles(req_t r);
    longint unsigned k;
    q_t dt, dt2;
    mode_t npl, npi;
    angles_t e;
    k = (r.mult == 0) ? 1 : r.mult;
    dt = q_t'((longint'(r.base_step) * k + 128) >> 8);
    dt2 = mul_q(dt, dt);
    npl = newmark_mode(plunge_st, r.f_plunge, regs[CFG_MASS_PLUNGE], regs[CFG_DAMPING_PLUNGE],
                       regs[CFG_OMEGA_PLUNGE], dt, dt2, startup);
    npi = newmark_mode(pitch_st, r.f_pitch, regs[CFG_MASS_PITCH], regs[CFG_DAMPING_PITCH],
                       regs[CFG_OMEGA_PITCH], dt, dt2, startup);
    e.pitch_angle = mul_q(npi.disp, regs[CFG_SHAPE_PITCH]);
    e.plunge_offset = mul_q(npl.disp, regs[CFG_SHAPE_PLUNGE]);
    angles_q.push_back(e);
    if (r.commit) begin
      plunge_st = npl;
      pitch_st = npi;
      startup = 0;
    end
  endtask

  task automatic report_mismatch(string what, q_t got, q_t want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // result side: random stalls, one long hold-off on demand
  // ---------------------------------------------------------------
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // checks each result against the oldest expected pair of angles
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (angles_q.size() == 0) begin
        errors++;
        $display("%0t result with no request pending", $realtime);
      end else begin
        e = angles_q.pop_front();
        if (out_if.pitch_angle !== e.pitch_angle)
          report_mismatch("pitch_angle", out_if.pitch_angle, e.pitch_angle);
        if (out_if.plunge_offset !== e.plunge_offset)
          report_mismatch("plunge_offset", out_if.plunge_offset, e.plunge_offset);
      end
    end
  end

  // ---------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------
  task automatic send_req(req_t r);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.force_plunge <= r.f_plunge;
    in_if.force_pitch <= r.f_pitch;
    in_if.base_step <= r.base_step;
    in_if.step_multiplier <= r.mult;
    in_if.commit <= r.commit;
    do @(posedge clk); while (!in_if.ready);
    predict_angles(r);
  endtask

  // drop valid once the last request of a phase has been taken
  task automatic end_requests();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // all results back, then a short settle before any register write
  task automatic wait_drain();
    while (angles_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // writes all eight registers, one per cycle
  task automatic load_regs(q_t vals [NUM_CFG]);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      regs[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic q_t rand_q48();
    return q_t'({$urandom, $urandom});
  endfunction

  function automatic q_t rand_small(int bits);
    longint x;
    x = longint'($urandom_range(0, (1 << bits) - 1)) << 8;
    return $urandom_range(0, 1) ? q_t'(-x) : q_t'(x);
  endfunction

  // mostly physical steps, some raw noise over the whole field range
  function automatic req_t rand_req();
    req_t r;
    if ($urandom_range(0, 6) == 0) begin
      r.f_plunge = rand_q48();
      r.f_pitch = rand_q48();
      r.base_step = $urandom;
      r.mult = 10'($urandom);
      r.commit = 1'($urandom);
    end else begin
      r.f_plunge = rand_small(24);
      r.f_pitch = rand_small(24);
      r.base_step = $urandom_range(0, 32'h0010_0000);
      r.mult = $urandom_range(0, 12);
      r.commit = ($urandom_range(0, 3) != 0);
    end
    return r;
  endfunction

  function automatic req_t mk_req(q_t fpl, q_t fpi, logic [31:0] bs, logic [9:0] k, logic c);
    req_t r;
    r.f_plunge = fpl;
    r.f_pitch = fpi;
    r.base_step = bs;
    r.mult = k;
    r.commit = c;
    return r;
  endfunction

  function automatic void reset_vals(output q_t v [NUM_CFG]);
    v[CFG_MASS_PLUNGE] = RST_MASS_PLUNGE;
    v[CFG_MASS_PITCH] = RST_MASS_PITCH;
    v[CFG_DAMPING_PLUNGE] = RST_DAMPING_PLUNGE;
    v[CFG_DAMPING_PITCH] = RST_DAMPING_PITCH;
    v[CFG_OMEGA_PLUNGE] = RST_OMEGA_PLUNGE;
    v[CFG_OMEGA_PITCH] = RST_OMEGA_PITCH;
    v[CFG_SHAPE_PLUNGE] = RST_SHAPE_PLUNGE;
    v[CFG_SHAPE_PITCH] = RST_SHAPE_PITCH;
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // start-up path before any commit, field extremes, then the first commit
  task automatic test_startup_and_extremes();
    send_req(mk_req('0, '0, '0, '0, 1'b0));
    send_req(mk_req(QMAX, QMIN, 32'hFFFF_FFFF, 10'd1023, 1'b0));
    send_req(mk_req(QMIN, QMAX, 32'h0000_0001, 10'd1, 1'b0));
    send_req(mk_req(48'sd16777216, -48'sd16777216, 32'h0004_0000, 10'd0, 1'b0));
    // first commit leaves the start-up path
    send_req(mk_req(48'sd16777216, 48'sd8388608, 32'h0004_0000, 10'd4, 1'b1));
    send_req(mk_req(48'sd33554432, -48'sd4194304, 32'h0002_0000, 10'd2, 1'b1));
    send_req(mk_req('0, '0, 32'hFFFF_FFFF, 10'd1023, 1'b0));
    send_req(mk_req(-48'sd1, 48'sd1, 32'h0000_0080, 10'd0, 1'b1));
    end_requests();
    wait_drain();
  endtask

  // register extremes, zero divisors and saturation
  task automatic test_register_extremes();
    q_t v [NUM_CFG];
    foreach (v[i]) v[i] = QMAX;
    load_regs(v);
    send_req(mk_req(QMAX, QMIN, 32'h0001_0000, 10'd3, 1'b0));
    send_req(mk_req(48'sd1000, -48'sd1000, 32'hFFFF_FFFF, 10'd1023, 1'b0));
    end_requests();
    wait_drain();
    foreach (v[i]) v[i] = QMIN;
    load_regs(v);
    send_req(mk_req(QMIN, QMAX, 32'h0001_0000, 10'd5, 1'b0));
    send_req(mk_req('0, 48'sd5, '0, '0, 1'b0));
    end_requests();
    wait_drain();
    // zero mass, damping and stiffness: quotient by zero
    foreach (v[i]) v[i] = '0;
    v[CFG_SHAPE_PLUNGE] = 48'sd16777216;
    v[CFG_SHAPE_PITCH] = -48'sd16777216;
    load_regs(v);
    send_req(mk_req(48'sd100, -48'sd100, '0, '0, 1'b0));
    send_req(mk_req('0, '0, '0, '0, 1'b0));
    send_req(mk_req(-48'sd7, 48'sd7, 32'h0000_1000, 10'd1, 1'b0));
    end_requests();
    wait_drain();
    reset_vals(v);
    load_regs(v);
  endtask

  // random requests under a few register settings
  task automatic test_random_steps(int n);
    q_t v [NUM_CFG];
    for (int p = 0; p < 4; p++) begin
      reset_vals(v);
      if (p > 0) begin
        v[CFG_MASS_PLUNGE] = q_t'($urandom_range(1 << 22, 1 << 26));
        v[CFG_MASS_PITCH] = q_t'($urandom_range(1 << 22, 1 << 26));
        v[CFG_DAMPING_PLUNGE] = q_t'($urandom_range(0, 1 << 23));
        v[CFG_DAMPING_PITCH] = q_t'($urandom_range(0, 1 << 23));
        v[CFG_OMEGA_PLUNGE] = q_t'($urandom_range(1 << 20, 1 << 30));
        v[CFG_OMEGA_PITCH] = q_t'($urandom_range(1 << 20, 1 << 30));
        v[CFG_SHAPE_PLUNGE] = rand_small(22);
        v[CFG_SHAPE_PITCH] = rand_small(22);
      end
      if (p == 3) foreach (v[i]) if ($urandom_range(0, 3) == 0) v[i] = rand_q48();
      load_regs(v);
      for (int i = 0; i < n / 4; i++) send_req(rand_req());
      end_requests();
      wait_drain();
    end
  endtask

  // receiver holds off while requests keep coming, input must stall
  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_req(rand_req());
    end_requests();
    wait_drain();
  endtask

  // back-to-back, no idling on either side
  task automatic test_streaming(int n);
    calm = 1;
    for (int i = 0; i < n; i++) send_req(rand_req());
    end_requests();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    calm = 0;
    hold_req = 0;
    reset_vals(regs);
    plunge_st = '{default: '0};
    pitch_st = '{default: '0};
    startup = 1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.force_plunge <= '0;
    in_if.force_pitch <= '0;
    in_if.base_step <= '0;
    in_if.step_multiplier <= '0;
    in_if.commit <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup_and_extremes();
    test_register_extremes();
    test_random_steps(400);
    test_backpressure();
    test_streaming(90);

    while (angles_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
